// ===== rtl/sitaf_pkg.sv =====
// ----------------------------------------------------------------------------
// sitaf_pkg: shared constants, types and helpers of the integer text formatter
// Holds the value width, the digit register geometry, the ASCII codes that
// the formatter emits and the control and status structs of the converter.
// ----------------------------------------------------------------------------
package sitaf_pkg;

    // Width of the signed input value that is formatted.
    localparam int VALUE_WIDTH = 64;
    // Largest digit count, also the most padding that min_digits can give.
    localparam int NUM_DIGITS  = 24;
    localparam int DIG_W       = 4 * NUM_DIGITS;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int POS_W       = $clog2(NUM_DIGITS);

    // Configuration register indexes.
    localparam logic [1:0] REG_HEX_MODE    = 2'd0;
    localparam logic [1:0] REG_MIN_DIGITS  = 2'd1;
    localparam logic [1:0] REG_SHOW_PREFIX = 2'd2;

    // ASCII codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;
    // Distance from the code after '9' to 'A'.
    localparam logic [7:0] HEX_GAP  = 8'd7;

    // Commands from the sequencer to the digit converter.
    typedef struct packed {
        logic load;        // take a new value and start the conversion
        logic hex;         // plain binary shift instead of shift-add-3
        logic shift_digit; // drop the top digit, shift the rest up
    } t_conv_ctrl;

    // Status from the digit converter.
    typedef struct packed {
        logic done;        // final conversion step is taking place
        logic neg;         // value of the item was negative
    } t_conv_stat;

    // ASCII code of one digit, upper-case for ten and above.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        c = CH_ZERO + {4'h0, d};
        if (d > 4'd9) begin
            c = c + HEX_GAP;
        end
        return c;
    endfunction

endpackage

// ===== rtl/signed_int_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_ascii_formatter: signed integer to ASCII text
// Formats each 64-bit signed value as decimal or upper-case hex text, one
// character per output transfer, with tlast on the final character.
// ----------------------------------------------------------------------------
// An item is first converted bit-serially (the digit converter takes in one
// bit of the value per step, with shift-add-3 in decimal). The sequencer then
// places the "0x" prefix when hex_mode and show_prefix are set, and steps
// through the digit positions from the 24th down to the first, placing the
// minus sign ahead of the first printed digit. Leading digit positions that
// print nothing still take a step each, and a stall on the output side holds
// the sequencer. A new value is taken once the final character has been
// placed in the output register, while that character still waits for its
// transfer. Configuration registers are at byte addresses 0 (hex_mode),
// 4 (min_digits) and 8 (show_prefix).
module signed_int_to_ascii_formatter import sitaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] value
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] character
    output logic        o_m_tlast,
    // Configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREFIX0,
        ST_PREFIX1,
        ST_SCAN
    } t_state;

    t_state           r_state;
    logic             r_hex_mode;
    logic [4:0]       r_min_digits;
    logic             r_show_prefix;
    logic [POS_W-1:0] r_pos;
    logic             r_seen;
    logic             r_sign_pending;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;

    t_conv_ctrl       ctrl;
    t_conv_stat       stat;
    logic [3:0]       top;
    logic [4:0]       need;
    logic             can_emit;
    logic             print_here;
    logic             load_out;
    logic             s_accept;
    logic             cfg_write;
    logic [1:0]       reg_idx;

    // Configuration writes and reads.
    assign reg_idx   = i_paddr[3:2];
    assign cfg_write = i_psel && i_penable && i_pwrite;
    assign o_pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_mode    <= 1'b0;
            r_min_digits  <= 5'd1;
            r_show_prefix <= 1'b1;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_HEX_MODE:    r_hex_mode    <= i_pwdata[0];
                REG_MIN_DIGITS:  r_min_digits  <= i_pwdata[4:0];
                REG_SHOW_PREFIX: r_show_prefix <= i_pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HEX_MODE:    o_prdata = {31'h0, r_hex_mode};
            REG_MIN_DIGITS:  o_prdata = {27'h0, r_min_digits};
            REG_SHOW_PREFIX: o_prdata = {31'h0, r_show_prefix};
            default:         o_prdata = '0;
        endcase
    end

    // Padding saturates at the digit register depth.
    assign need = (r_min_digits > 5'(NUM_DIGITS)) ? 5'(NUM_DIGITS) : r_min_digits;

    // A position prints when padding asks for it, a digit has already
    // printed, its digit is nonzero, or it is the units position.
    assign print_here = (5'(r_pos) < need) || r_seen || (top != 4'h0) || (r_pos == '0);

    assign can_emit   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // The output register takes every character that the sequencer places.
    assign load_out = can_emit && ((r_state == ST_PREFIX0) || (r_state == ST_PREFIX1) ||
                                   ((r_state == ST_SCAN) && print_here));

    // Converter commands.
    always_comb begin
        ctrl.load        = s_accept;
        ctrl.hex         = r_hex_mode;
        ctrl.shift_digit = 1'b0;
        if (r_state == ST_SCAN) begin
            if (!print_here) begin
                ctrl.shift_digit = 1'b1;
            end else if (can_emit && !r_sign_pending) begin
                ctrl.shift_digit = 1'b1;
            end
        end
    end

    sitaf_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_value (i_s_tdata[VALUE_WIDTH-1:0]),
        .o_stat  (stat),
        .o_top   (top)
    );

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_pos          <= '0;
            r_seen         <= 1'b0;
            r_sign_pending <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (stat.done) begin
                        r_pos          <= POS_W'(NUM_DIGITS - 1);
                        r_seen         <= 1'b0;
                        r_sign_pending <= stat.neg;
                        if (r_hex_mode && r_show_prefix) begin
                            r_state <= ST_PREFIX0;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_PREFIX0: begin
                    if (can_emit) begin
                        r_out_char  <= CH_ZERO;
                        r_out_last  <= 1'b0;
                        r_state     <= ST_PREFIX1;
                    end
                end
                ST_PREFIX1: begin
                    if (can_emit) begin
                        r_out_char  <= CH_X;
                        r_out_last  <= 1'b0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!print_here) begin
                        r_pos <= r_pos - 1'b1;
                    end else if (can_emit) begin
                        r_seen      <= 1'b1;
                        if (r_sign_pending) begin
                            r_out_char     <= CH_MINUS;
                            r_out_last     <= 1'b0;
                            r_sign_pending <= 1'b0;
                        end else begin
                            r_out_char <= digit_char(top);
                            r_out_last <= (r_pos == '0);
                            r_pos      <= r_pos - 1'b1;
                            if (r_pos == '0) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/sitaf_dabble.sv =====
// ----------------------------------------------------------------------------
// sitaf_dabble: magnitude to digit conversion, one bit per cycle
// Takes the magnitude of the value and shifts it, most significant bit first,
// into a register of four-bit digits. In decimal each digit of five or more
// gets three added before the shift; in hex the bits shift in unchanged.
// After conversion the digits leave from the top, one per shift command.
// ----------------------------------------------------------------------------
module sitaf_dabble import sitaf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_conv_ctrl             i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output t_conv_stat             o_stat,
    output logic [3:0]             o_top
);

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [DIG_W-1:0]       r_digits;
    logic [DIG_W-1:0]       adj;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_hex;
    logic                   r_neg;

    // Add three to each decimal digit of five or more ahead of the shift.
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (!r_hex && r_digits[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_digits[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_digits[4*k +: 4];
            end
        end
    end

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.load) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(VALUE_WIDTH - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Magnitude and digit shift registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_neg    <= i_value[VALUE_WIDTH-1];
            r_hex    <= i_ctrl.hex;
            r_digits <= '0;
            if (i_value[VALUE_WIDTH-1]) begin
                r_mag <= ~i_value + 1'b1;
            end else begin
                r_mag <= i_value;
            end
        end else if (r_busy) begin
            r_mag    <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
            r_digits <= {adj[DIG_W-2:0], r_mag[VALUE_WIDTH-1]};
        end else if (i_ctrl.shift_digit) begin
            r_digits <= {r_digits[DIG_W-5:0], 4'h0};
        end
    end

    assign o_stat.done = r_busy && (r_cnt == '0);
    assign o_stat.neg  = r_neg;
    assign o_top       = r_digits[DIG_W-1 -: 4];

endmodule
